### rtl/core/bounded_array_deque_core_assert.svh
// Assertion macros for the bounded array deque core
`ifndef BOUNDED_ARRAY_DEQUE_CORE_ASSERT_SVH
`define BOUNDED_ARRAY_DEQUE_CORE_ASSERT_SVH

// check cons in the same cycle as ante
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/bdeque_pkg.sv
// Types and codes shared by the bounded array deque core
package bdeque_pkg;

	localparam int DEPTH_DEF = 16;

	typedef logic [2:0] mode_t;
	typedef logic [1:0] status_t;

	localparam mode_t MODE_PUSH_FRONT = 3'd0;
	localparam mode_t MODE_PUSH_BACK  = 3'd1;
	localparam mode_t MODE_POP_FRONT  = 3'd2;
	localparam mode_t MODE_POP_BACK   = 3'd3;
	localparam mode_t MODE_DUMP       = 3'd4;

	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_FULL  = 2'd1;
	localparam status_t STAT_EMPTY = 2'd2;

endpackage

### rtl/core/bounded_array_deque_core.sv
// Bounded deque of signed 32-bit entries held in a circular-buffer memory
//
// Request channel (req_valid, req_stall, mode, value): one item per operation.
// Modes push at the front or back, pop at the front or back, or dump the list.
// Response channel (rsp_valid, rsp_stall, status, count, entry_index,
// entry_value, last): push, pop and unknown modes give one item, a dump gives
// one item per stored entry from index 0 upward, or one empty item.
// The last flag marks the final response item of each request.
// A response item is loaded into the output register when its request is taken;
// a dump of a nonempty list gives its first item behind one memory read.
// Throughput: push, pop and empty dumps accept one request per cycle while the
// response is not stalled; a dump of N entries stalls the request channel until
// its last entry is loaded, one memory read per entry through the single
// read port.
// Reset clears the fill count and head pointer; memory contents are not
// cleared and only written positions are ever read.
// A stalled response holds its item and stalls the request channel while a
// new item cannot be loaded; a dump pauses and resumes without loss.
`include "bounded_array_deque_core_assert.svh"

module bounded_array_deque_core #(
	parameter int DEPTH = bdeque_pkg::DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bdeque_pkg::mode_t   mode,
	input  logic signed [31:0]  value,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bdeque_pkg::status_t status,
	output logic [CNT_W-1:0]    count,
	output logic [IDX_W-1:0]    entry_index,
	output logic signed [31:0]  entry_value,
	output logic                last
);
	import bdeque_pkg::*;

	localparam logic [IDX_W-1:0] LAST_PTR = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
	localparam logic [CNT_W:0]   WRAP_SUM = (CNT_W + 1)'(DEPTH);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_DUMP = 1'b1;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_data_s1;

	logic [0:0]       state_q;
	logic [IDX_W-1:0] head_q, rd_ptr_q, dump_idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	status_t          status_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic signed [31:0] val_q;
	logic             last_q;

	logic             req_acc, out_free, full, empty;
	logic [IDX_W-1:0] head_inc, head_dec, tail_ptr, rd_ptr_nxt, rd_addr, wr_addr;
	logic [CNT_W:0]   tail_sum;
	logic [IDX_W-1:0] head_nxt;
	logic [CNT_W-1:0] cnt_nxt;
	status_t          res_status;
	logic             wr_req, do_write, start_dump, dump_load, dump_last, rd_en;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q == ST_DUMP) || !out_free;
	assign req_acc   = req_valid && !req_stall;
	assign full      = (cnt_q == FULL_CNT);
	assign empty     = (cnt_q == '0);

	assign head_inc   = (head_q == LAST_PTR) ? '0 : head_q + IDX_W'(1);
	assign head_dec   = (head_q == '0) ? LAST_PTR : head_q - IDX_W'(1);
	assign rd_ptr_nxt = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + IDX_W'(1);
	assign tail_sum   = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(cnt_q);
	assign tail_ptr   = (tail_sum >= WRAP_SUM) ? IDX_W'(tail_sum - WRAP_SUM)
		: IDX_W'(tail_sum);

	always_comb begin
		res_status = STAT_OK;
		wr_req     = 1'b0;
		wr_addr    = head_dec;
		head_nxt   = head_q;
		cnt_nxt    = cnt_q;
		start_dump = 1'b0;
		unique case (mode)
			MODE_PUSH_FRONT: begin
				if (full) begin
					res_status = STAT_FULL;
				end else begin
					wr_req   = 1'b1;
					wr_addr  = head_dec;
					head_nxt = head_dec;
					cnt_nxt  = cnt_q + CNT_W'(1);
				end
			end
			MODE_PUSH_BACK: begin
				if (full) begin
					res_status = STAT_FULL;
				end else begin
					wr_req  = 1'b1;
					wr_addr = tail_ptr;
					cnt_nxt = cnt_q + CNT_W'(1);
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					head_nxt = head_inc;
					cnt_nxt  = cnt_q - CNT_W'(1);
				end
			end
			MODE_POP_BACK: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					cnt_nxt = cnt_q - CNT_W'(1);
				end
			end
			MODE_DUMP: begin
				if (empty) begin
					res_status = STAT_EMPTY;
				end else begin
					start_dump = 1'b1;
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	assign do_write  = req_acc && wr_req;
	assign dump_load = (state_q == ST_DUMP) && out_free;
	assign dump_last = (CNT_W'(dump_idx_q) + CNT_W'(1)) == cnt_q;
	assign rd_en     = (req_acc && start_dump) || (dump_load && !dump_last);
	assign rd_addr   = (state_q == ST_DUMP) ? rd_ptr_nxt : head_q;

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr_addr] <= value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			rd_ptr_q    <= '0;
			dump_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_acc) begin
				head_q <= head_nxt;
				cnt_q  <= cnt_nxt;
			end
			if (req_acc && start_dump) begin
				state_q    <= ST_DUMP;
				rd_ptr_q   <= head_q;
				dump_idx_q <= '0;
			end else if (dump_load) begin
				rd_ptr_q   <= rd_ptr_nxt;
				dump_idx_q <= dump_idx_q + IDX_W'(1);
				if (dump_last) begin
					state_q <= ST_IDLE;
				end
			end
			if ((req_acc && !start_dump) || dump_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && !start_dump) begin
			status_q <= res_status;
			count_q  <= cnt_nxt;
			idx_q    <= '0;
			val_q    <= '0;
			last_q   <= 1'b1;
		end else if (dump_load) begin
			status_q <= STAT_OK;
			count_q  <= cnt_q;
			idx_q    <= dump_idx_q;
			val_q    <= rd_data_s1;
			last_q   <= dump_last;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign count       = count_q;
	assign entry_index = idx_q;
	assign entry_value = val_q;
	assign last        = last_q;

	`BDQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= FULL_CNT, "fill count above depth")
	`BDQ_ASSERT_NOW(a_dump_nonempty, state_q == ST_DUMP, cnt_q != '0, "dump of empty list")
	`BDQ_ASSERT_NEXT(a_dump_end, dump_load && dump_last, state_q == ST_IDLE, "dump overran")
	`BDQ_ASSERT_NEXT(a_cnt_hold, !req_acc, $stable(cnt_q), "count moved without item")
	`BDQ_ASSERT_NOW(a_idx_range, rsp_valid_q, CNT_W'(idx_q) < count_q || idx_q == '0, "bad index")

endmodule
